### rtl/dbla_pkg.sv
// Shared types and constants for the dwell binned load averager.
package dbla_pkg;

  // Action codes of an input item.
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // Result status codes.
  localparam logic [3:0] ST_WAITING  = 4'd0;
  localparam logic [3:0] ST_MEASURE  = 4'd1;
  localparam logic [3:0] ST_DRIFT    = 4'd2;
  localparam logic [3:0] ST_PULSEERR = 4'd3;
  localparam logic [3:0] ST_STORED   = 4'd4;
  localparam logic [3:0] ST_TAKEN    = 4'd5;
  localparam logic [3:0] ST_NOSAMP   = 4'd6;
  localparam logic [3:0] ST_READ     = 4'd7;
  localparam logic [3:0] ST_CLEARED  = 4'd8;

  // Configuration register indexes.
  localparam logic [2:0] REG_PULSE_ZERO = 3'd0;
  localparam logic [2:0] REG_PULSE_FULL = 3'd1;
  localparam logic [2:0] REG_DRIFT      = 3'd2;
  localparam logic [2:0] REG_DWELL      = 3'd3;
  localparam logic [2:0] REG_WINDOW     = 3'd4;

  localparam int PERCENT_TOP = 100;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Classified item passed from the front to the back.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic        pulse_zero;
    logic [16:0] pulse_diff;   // pulse - zero point, signed
    logic        load_valid;
    logic [31:0] load_value;
    logic [6:0]  read_index;
  } item_t;

  // Result beat.
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] throttle_percent;
    logic [6:0]  bin_index;
    logic [31:0] bin_value;
    logic        bin_filled;
  } result_t;

endpackage

### rtl/dwell_binned_load_averager_core.sv
// Top level of the dwell binned load averager.
//  channel | handshake        | payload
//  input   | push / full      | action, now_ms, pulse_us, load_valid, load_value, read_index
//  result  | empty / pop      | status, throttle_percent, bin_index, bin_value, bin_filled
//  config  | cfg_valid/ready  | cfg_index, cfg_data
// A sample with a nonzero pulse and span runs the 64-step shared divider once
// for the throttle map, and once more when an average is stored. Reset is
// synchronous; bins read as empty after reset and after a clear. A held result
// stalls the back end at its output; the front and the two-entry queue keep
// taking items meanwhile.
module dwell_binned_load_averager_core import dbla_pkg::*; #(
  parameter int NUM_BINS = 101
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [31:0] now_ms,
  input  logic [14:0] pulse_us,
  input  logic        load_valid,
  input  logic signed [31:0] load_value,
  input  logic [6:0]  read_index,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  status,
  output logic signed [15:0] throttle_percent,
  output logic [6:0]  bin_index,
  output logic signed [31:0] bin_value,
  output logic        bin_filled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [14:0] pulse_at_zero, pulse_at_full;
  logic [6:0]  drift_percent;
  logic [15:0] dwell_ms, window_ms;

  assign cfg_ready = 1'b1;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_at_zero <= 15'd1000;
      pulse_at_full <= 15'd2000;
      drift_percent <= 7'd5;
      dwell_ms <= 16'd500;
      window_ms <= 16'd500;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PULSE_ZERO: pulse_at_zero <= cfg_data[14:0];
        REG_PULSE_FULL: pulse_at_full <= cfg_data[14:0];
        REG_DRIFT:      drift_percent <= cfg_data[6:0];
        REG_DWELL:      dwell_ms <= cfg_data;
        REG_WINDOW:     window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  logic  f_push, f_full, q_empty, q_pop;
  item_t f_item, q_item;
  logic  res_valid;
  result_t res;

  dbla_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .now_ms(now_ms), .pulse_us(pulse_us), .load_valid(load_valid),
    .load_value(load_value), .read_index(read_index),
    .pulse_at_zero(pulse_at_zero), .q_push(f_push), .q_full(f_full), .q_item(f_item)
  );

  dbla_queue u_queue (
    .clk(clk), .rst(rst), .wr(f_push), .full(f_full), .wdata(f_item),
    .rd(q_pop), .empty(q_empty), .rdata(q_item)
  );

  dbla_back #(.NUM_BINS(NUM_BINS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_pop(q_pop), .q_item(q_item),
    .pulse_at_zero(pulse_at_zero), .pulse_at_full(pulse_at_full),
    .drift_percent(drift_percent), .dwell_ms(dwell_ms), .window_ms(window_ms),
    .res_valid(res_valid), .res_taken(pop), .res(res)
  );

  assign empty = !res_valid;
  assign status = res.status;
  assign throttle_percent = res.throttle_percent;
  assign bin_index = res.bin_index;
  assign bin_value = res.bin_value;
  assign bin_filled = res.bin_filled;

  // A result never shows a status code above cleared.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status <= ST_CLEARED) else $error("bad status");

  // A pulse error never carries a throttle value.
  a_err_pct: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_PULSEERR) |-> throttle_percent == 16'sd0)
    else $error("pulse error with percent");

  // A stored or taken result always reports a filled bin.
  a_stored_filled: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == ST_STORED || status == ST_TAKEN)) |-> bin_filled)
    else $error("stored bin not filled");
endmodule

### rtl/dbla_divider.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
module dbla_divider import dbla_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic [W-1:0] dvs;
  logic [CW-1:0] count;
  logic busy;
  logic [W:0] trial;

  assign trial = {rem, quo[W-1]} - {1'b0, dvs};
  assign quotient = quo;

  // Shift one bit, subtract if it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(W);
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/dbla_front.sv
// Front stage: take input items and work out the pulse offset from the zero point.
module dbla_front import dbla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [31:0] now_ms,
  input  logic [14:0] pulse_us,
  input  logic        load_valid,
  input  logic [31:0] load_value,
  input  logic [6:0]  read_index,
  input  logic [14:0] pulse_at_zero,
  output logic        q_push,
  input  logic        q_full,
  output item_t       q_item
);
  item_t hold;
  logic  held;

  assign full = held;
  assign q_push = held && !q_full;
  assign q_item = hold;

  // Capture one beat, release it to the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (push && !held) begin
        held <= 1'b1;
        hold.action <= action;
        hold.now_ms <= now_ms;
        hold.pulse_zero <= (pulse_us == '0);
        hold.pulse_diff <= {2'b00, pulse_us} - {2'b00, pulse_at_zero};
        hold.load_valid <= load_valid;
        hold.load_value <= load_value;
        hold.read_index <= read_index;
      end else if (q_push) begin
        held <= 1'b0;
      end
    end
  end
endmodule

### rtl/dbla_queue.sv
// Two-entry queue between the front and the back.
module dbla_queue import dbla_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  output logic  full,
  input  item_t wdata,
  input  logic  rd,
  output logic  empty,
  output item_t rdata
);
  item_t slot [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slot[rptr];

  // Advance pointers on each beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        slot[wptr] <= wdata;
        wptr <= !wptr;
      end
      if (rd && !empty) rptr <= !rptr;
      count <= count + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end
endmodule

### rtl/dbla_back.sv
// Back stage: sequencer for mapping, drift test, averaging and bins.
module dbla_back import dbla_pkg::*; #(
  parameter int NUM_BINS = 101
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  output logic        q_pop,
  input  item_t       q_item,
  input  logic [14:0] pulse_at_zero,
  input  logic [14:0] pulse_at_full,
  input  logic [6:0]  drift_percent,
  input  logic [15:0] dwell_ms,
  input  logic [15:0] window_ms,
  output logic        res_valid,
  input  logic        res_taken,
  output result_t     res
);
  localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int TOP = (NUM_BINS - 1 < PERCENT_TOP) ? NUM_BINS - 1 : PERCENT_TOP;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAP   = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_AVG   = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_CLEAR = 3'd7;

  logic [2:0] state;
  item_t cur;
  result_t work;

  // Measurement state.
  logic        mode;
  logic        dwell_running;
  logic [31:0] phase_start_ms;
  logic [15:0] reference_percent;
  logic [47:0] load_total;
  logic [15:0] load_samples;

  // Bins: memory plus valid flags.
  logic [31:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0] bin_taken;
  logic [31:0] mem_q;
  logic [BW-1:0] bin_sel;
  logic          rd_in_range;

  // Divider.
  logic        div_start, div_done;
  logic [63:0] div_a, div_b, div_q;
  logic        div_neg;
  logic        map_div;

  dbla_divider #(.W(64)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  logic [15:0] pct;
  logic [16:0] den;
  logic [63:0] num_mag;
  logic [63:0] sq;
  logic [15:0] sat_pct;

  assign den = {2'b00, pulse_at_full} - {2'b00, pulse_at_zero};
  assign num_mag = cur.pulse_diff[16] ? 64'(-$signed(cur.pulse_diff)) * 64'd100
                                      : 64'(cur.pulse_diff) * 64'd100;
  assign sq = div_neg ? -div_q : div_q;
  assign sat_pct = ($signed(sq) > 64'sd32767) ? 16'h7FFF :
                   ($signed(sq) < -64'sd32768) ? 16'h8000 : sq[15:0];

  // Drift test against the reference in use.
  logic [15:0] ref_use;
  logic [17:0] diff_abs, ref_abs;
  logic [24:0] lhs, rhs;
  logic        steady;
  logic [31:0] elapsed;
  logic [47:0] total_add;
  logic [15:0] samp_add;

  always_comb begin
    ref_use = (!mode && !dwell_running) ? pct : reference_percent;
    diff_abs = 18'($signed(pct) - $signed(ref_use));
    if (diff_abs[17]) diff_abs = -diff_abs;
    ref_abs = ref_use[15] ? 18'(-$signed({ref_use[15], ref_use})) : {2'b00, ref_use};
    lhs = 25'(diff_abs) * 25'd100;
    rhs = 25'(ref_abs) * 25'(drift_percent);
    steady = lhs <= rhs;
    elapsed = cur.now_ms - ((!mode && !dwell_running) ? cur.now_ms : phase_start_ms);
    total_add = load_total;
    samp_add = load_samples;
    if (cur.load_valid && load_samples != COUNT_MAX) begin
      total_add = load_total + 48'($signed(cur.load_value));
      samp_add = load_samples + 16'd1;
    end
  end

  logic [BW-1:0] clamp_bin;
  always_comb begin
    if (reference_percent[15]) clamp_bin = '0;
    else if ($signed(reference_percent) > TOP) clamp_bin = BW'(TOP);
    else clamp_bin = reference_percent[BW-1:0];
  end

  assign rd_in_range = ({25'd0, cur.read_index} < NUM_BINS);
  assign q_pop = (state == S_IDLE) && !q_empty;

  logic          mem_wr;
  logic [31:0]   mem_wd;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_wr) bin_mem[bin_sel] <= mem_wd;
    mem_q <= bin_mem[bin_sel];
  end

  // Sequence one item through the stages.
  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    mem_wr <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      mode <= 1'b0;
      dwell_running <= 1'b0;
      phase_start_ms <= '0;
      reference_percent <= '0;
      load_total <= '0;
      load_samples <= '0;
      bin_taken <= '0;
      map_div <= 1'b0;
    end else begin
      // Raise the result beat when one is finished, drop it once taken.
      if (state == S_OUT && (!res_valid || res_taken)) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_taken) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_item;
            work <= '0;
            state <= S_MAP;
          end
        end
        S_MAP: begin
          work.throttle_percent <= '0;
          unique case (cur.action)
            ACT_CLEAR: begin
              bin_taken <= '0;
              mode <= 1'b0;
              dwell_running <= 1'b0;
              work.status <= ST_CLEARED;
              state <= S_OUT;
            end
            ACT_READ: begin
              work.status <= ST_READ;
              work.bin_index <= cur.read_index;
              bin_sel <= BW'(cur.read_index);
              state <= S_READ;
            end
            ACT_NONE: begin
              work.status <= {3'd0, mode};
              state <= S_OUT;
            end
            default: begin
              if (cur.pulse_zero) begin
                mode <= 1'b0;
                dwell_running <= 1'b0;
                work.status <= ST_PULSEERR;
                state <= S_OUT;
              end else if (den == '0) begin
                pct <= '0;
                state <= S_EVAL;
              end else begin
                div_a <= num_mag;
                div_b <= den[16] ? 64'(-$signed(den)) : 64'(den);
                div_neg <= cur.pulse_diff[16] ^ den[16];
                div_start <= 1'b1;
                map_div <= 1'b1;
                state <= S_AVG;
              end
            end
          endcase
        end
        S_READ: state <= S_STORE;
        S_STORE: begin
          if (cur.action == ACT_READ) begin
            if (rd_in_range) begin
              work.bin_value <= bin_taken[bin_sel] ? mem_q : 32'd0;
              work.bin_filled <= bin_taken[bin_sel];
            end
          end else begin
            work.bin_value <= bin_taken[bin_sel] ? mem_q : 32'd0;
            work.bin_filled <= bin_taken[bin_sel];
          end
          state <= S_OUT;
        end
        S_AVG: begin
          if (div_done) begin
            if (map_div) begin
              map_div <= 1'b0;
              pct <= sat_pct;
              state <= S_EVAL;
            end else begin
              // Write the new average and show it directly.
              bin_sel <= clamp_bin;
              mem_wd <= sq[31:0];
              mem_wr <= 1'b1;
              bin_taken[clamp_bin] <= 1'b1;
              work.status <= ST_STORED;
              work.bin_index <= 7'(clamp_bin);
              work.bin_value <= sq[31:0];
              work.bin_filled <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_EVAL: begin
          work.throttle_percent <= pct;
          state <= S_OUT;
          if (!mode) begin
            if (!dwell_running) begin
              phase_start_ms <= cur.now_ms;
              reference_percent <= pct;
              dwell_running <= 1'b1;
            end
            if (!steady) begin
              dwell_running <= 1'b0;
              work.status <= ST_DRIFT;
            end else if (elapsed > {16'd0, dwell_ms}) begin
              reference_percent <= pct;
              load_total <= '0;
              load_samples <= '0;
              phase_start_ms <= cur.now_ms;
              mode <= 1'b1;
              work.status <= ST_MEASURE;
            end else begin
              work.status <= ST_WAITING;
            end
          end else if (!steady) begin
            mode <= 1'b0;
            dwell_running <= 1'b0;
            work.status <= ST_DRIFT;
          end else begin
            load_total <= total_add;
            load_samples <= samp_add;
            if (elapsed > {16'd0, window_ms}) begin
              mode <= 1'b0;
              dwell_running <= 1'b0;
              work.bin_index <= 7'(clamp_bin);
              bin_sel <= clamp_bin;
              if (samp_add == '0) begin
                work.status <= ST_NOSAMP;
                state <= S_READ;
              end else if (bin_taken[clamp_bin]) begin
                work.status <= ST_TAKEN;
                state <= S_READ;
              end else begin
                // Round half away from zero on the magnitude.
                div_a <= (total_add[47] ? 64'(-$signed(total_add)) : 64'(total_add))
                         + 64'(samp_add[15:1]);
                div_b <= 64'(samp_add);
                div_neg <= total_add[47];
                div_start <= 1'b1;
                state <= S_AVG;
              end
            end else begin
              work.status <= ST_MEASURE;
            end
          end
        end
        S_OUT: begin
          if (!res_valid || res_taken) begin
            res <= work;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/tb.sv
// Self-checking testbench for the dwell binned load averager core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbla_pkg::*;

  localparam int BIN_COUNT = 101;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] action = ACT_SAMPLE;
  logic [31:0] now_ms = '0;
  logic [14:0] pulse_us = '0;
  logic load_valid = 1'b0;
  logic signed [31:0] load_value = '0;
  logic [6:0] read_index = '0;
  logic empty;
  logic pop = 1'b0;
  logic [3:0] status;
  logic signed [15:0] throttle_percent;
  logic [6:0] bin_index;
  logic signed [31:0] bin_value;
  logic bin_filled;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dwell_binned_load_averager_core #(.NUM_BINS(BIN_COUNT)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model copy of configuration and state
  int unsigned zero_pt, full_pt, drift_pct, dwell_len, window_len;
  bit measuring, dwell_on;
  logic [31:0] phase_start;
  int ref_pct;
  longint load_sum;
  int unsigned load_cnt;
  int bin_avg [BIN_COUNT];
  bit bin_used [BIN_COUNT];

  result_t expected_results[$];
  int errors = 0;
  int unsigned cycle_count = 0;
  int send_idle = 0, recv_idle = 0;
  logic [31:0] clock_ms = 0;

  task automatic model_reset();
    zero_pt = 1000; full_pt = 2000; drift_pct = 5; dwell_len = 500; window_len = 500;
    measuring = 0; dwell_on = 0; phase_start = 0; ref_pct = 0;
    load_sum = 0; load_cnt = 0;
    for (int i = 0; i < BIN_COUNT; i++) begin
      bin_avg[i] = 0;
      bin_used[i] = 0;
    end
  endtask

  function automatic int throttle_of(int unsigned pw);
    longint num, den, p;
    num = (longint'(pw) - longint'(zero_pt)) * 100;
    den = longint'(full_pt) - longint'(zero_pt);
    if (den == 0) return 0;
    p = num / den;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return int'(p);
  endfunction

  function automatic bit within_drift(int p, int r);
    longint d, m;
    d = longint'(p) - longint'(r);
    m = r < 0 ? -longint'(r) : longint'(r);
    if (d < 0) d = -d;
    return d * 100 <= longint'(drift_pct) * m;
  endfunction

  function automatic int rounded_mean();
    longint unsigned mag, q;
    mag = load_sum < 0 ? longint'(-load_sum) : load_sum;
    q = (mag + load_cnt / 2) / load_cnt;
    return load_sum < 0 ? int'(-longint'(q)) : int'(q);
  endfunction

  // Compute the result of one item and advance the model
  task automatic predict_result(input logic [1:0] act, input logic [31:0] tnow,
                                input int unsigned pw, input bit lv,
                                input logic signed [31:0] lval, input int unsigned ridx);
    result_t r;
    int p, b;
    bit show;
    r = '0; p = 0; show = 0; b = 0;
    if (act == ACT_CLEAR) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
        bin_avg[i] = 0;
        bin_used[i] = 0;
      end
      measuring = 0; dwell_on = 0;
      r.status = ST_CLEARED;
    end else if (act == ACT_READ) begin
      r.status = ST_READ;
      r.bin_index = ridx[6:0];
      if (ridx < BIN_COUNT) begin
        r.bin_value = bin_avg[ridx];
        r.bin_filled = bin_used[ridx];
      end
    end else if (act == ACT_NONE) begin
      r.status = measuring ? ST_MEASURE : ST_WAITING;
    end else if (pw == 0) begin
      measuring = 0; dwell_on = 0;
      r.status = ST_PULSEERR;
    end else begin
      p = throttle_of(pw);
      if (!measuring) begin
        if (!dwell_on) begin
          phase_start = tnow; ref_pct = p; dwell_on = 1;
        end
        if (!within_drift(p, ref_pct)) begin
          dwell_on = 0;
          r.status = ST_DRIFT;
        end else if (32'(tnow - phase_start) > dwell_len) begin
          ref_pct = p; load_sum = 0; load_cnt = 0; phase_start = tnow;
          measuring = 1;
          r.status = ST_MEASURE;
        end else begin
          r.status = ST_WAITING;
        end
      end else if (!within_drift(p, ref_pct)) begin
        measuring = 0; dwell_on = 0;
        r.status = ST_DRIFT;
      end else begin
        if (lv && load_cnt < 65535) begin
          load_sum += longint'(lval);
          load_cnt++;
        end
        if (32'(tnow - phase_start) > window_len) begin
          b = ref_pct < 0 ? 0 : (ref_pct > 100 ? 100 : ref_pct);
          if (load_cnt > 0) begin
            if (!bin_used[b]) begin
              bin_avg[b] = rounded_mean();
              bin_used[b] = 1;
              r.status = ST_STORED;
            end else begin
              r.status = ST_TAKEN;
            end
          end else begin
            r.status = ST_NOSAMP;
          end
          show = 1;
          measuring = 0; dwell_on = 0;
        end else begin
          r.status = ST_MEASURE;
        end
      end
    end
    r.throttle_percent = p[15:0];
    if (show) begin
      r.bin_index = 7'(b);
      r.bin_value = bin_avg[b];
      r.bin_filled = bin_used[b];
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Pop side: random stall, check each beat against the oldest expectation
  always @(posedge clk) begin
    result_t w;
    cycle_count <= cycle_count + 1;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'(status), 32'd0);
      end else begin
        w = expected_results.pop_front();
        if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
        if (throttle_percent !== w.throttle_percent)
          report_mismatch("throttle_percent", 32'(throttle_percent),
                          32'(w.throttle_percent));
        if (bin_index !== w.bin_index)
          report_mismatch("bin_index", 32'(bin_index), 32'(w.bin_index));
        if (bin_value !== w.bin_value) report_mismatch("bin_value", bin_value, w.bin_value);
        if (bin_filled !== w.bin_filled)
          report_mismatch("bin_filled", 32'(bin_filled), 32'(w.bin_filled));
      end
    end
    pop <= ($urandom_range(99) >= recv_idle);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Send one item beat, with random idle before it; push stays up after the
  // accepting edge until the next item or a drain takes it down
  task automatic send_item(input logic [1:0] act, input logic [31:0] tnow,
                           input int unsigned pw, input bit lv,
                           input logic signed [31:0] lval, input int unsigned ridx);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    action <= act; now_ms <= tnow; pulse_us <= pw[14:0];
    load_valid <= lv; load_value <= lval; read_index <= ridx[6:0];
    @(posedge clk);
    while (full) @(posedge clk);
    predict_result(act, tnow, pw, lv, lval, ridx);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PULSE_ZERO: zero_pt = val & 16'h7FFF;
      REG_PULSE_FULL: full_pt = val & 16'h7FFF;
      REG_DRIFT: drift_pct = val & 7'h7F;
      REG_DWELL: dwell_len = val & 16'hFFFF;
      default: window_len = val & 16'hFFFF;
    endcase
  endtask

  task automatic set_config(input int unsigned z, input int unsigned f, input int unsigned d,
                            input int unsigned dw, input int unsigned wn);
    drain();
    write_reg(REG_PULSE_ZERO, z);
    write_reg(REG_PULSE_FULL, f);
    write_reg(REG_DRIFT, d);
    write_reg(REG_DWELL, dw);
    write_reg(REG_WINDOW, wn);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_load();
    case ($urandom_range(3))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Directed: each action, pulse extremes, read range, store and taken bin
  task automatic test_directed();
    send_item(ACT_READ, 0, 0, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 0, 0, 127);
    send_item(ACT_READ, 0, 0, 0, 0, 100);
    send_item(ACT_NONE, 32'hFFFFFFFF, 30000, 1, -1, 5);
    send_item(ACT_SAMPLE, 10, 0, 1, 5, 0);
    send_item(ACT_SAMPLE, 10, 32767, 0, 0, 0);
    send_item(ACT_SAMPLE, 10, 1, 0, 0, 0);
    send_item(ACT_SAMPLE, 20, 1500, 0, 0, 0);
    send_item(ACT_SAMPLE, 30, 1800, 0, 0, 0);
    for (int k = 0; k < 2; k++) begin
      send_item(ACT_SAMPLE, 1000 + k * 2000, 1500, 0, 0, 0);
      send_item(ACT_SAMPLE, 1600 + k * 2000, 1500, 0, 0, 0);
      send_item(ACT_NONE, 0, 0, 0, 0, 0);
      send_item(ACT_SAMPLE, 1700 + k * 2000, 1510, 1, 32'sh7FFFFFFF, 0);
      send_item(ACT_SAMPLE, 1800 + k * 2000, 1490, 1, 32'sh7FFFFFFF, 0);
      send_item(ACT_SAMPLE, 2200 + k * 2000, 1500, 1, -3, 0);
    end
    send_item(ACT_READ, 0, 0, 0, 0, 50);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
    send_item(ACT_READ, 0, 0, 0, 0, 50);
  endtask

  // Random: mostly steady runs through dwell and window, some noise
  task automatic test_random(input int count);
    int sent, base, len;
    bit lv;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 7) begin
        base = $urandom_range(full_pt + 200);
        if ($urandom_range(7) == 0) base = $urandom_range(30000);
        len = $urandom_range(4, 14);
        for (int j = 0; j < len; j++) begin
          clock_ms += $urandom_range(window_len / 2 + dwell_len / 2 + 2);
          if ($urandom_range(15) == 0) clock_ms += $urandom;
          lv = $urandom_range(3) != 0;
          send_item(ACT_SAMPLE, clock_ms,
                    ($urandom_range(9) == 0) ? $urandom_range(30000) : base,
                    lv, rand_load(), 0);
        end
        sent += len;
      end else begin
        case ($urandom_range(5))
          0: send_item(ACT_CLEAR, $urandom, $urandom_range(32767), $urandom_range(1),
                       $urandom, $urandom_range(127));
          1: send_item(ACT_NONE, $urandom, $urandom_range(32767), $urandom_range(1),
                       $urandom, $urandom_range(127));
          2: send_item(ACT_SAMPLE, $urandom, 0, 1, $urandom, 0);
          default: send_item(ACT_READ, $urandom, $urandom_range(32767), $urandom_range(1),
                             $urandom, ($urandom_range(3) == 0) ? $urandom_range(127)
                                                                : $urandom_range(100));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 34; recv_idle = 65;
    test_directed();
    test_random(300);
    // Extremes of every register, short times for frequent stores
    set_config(0, 30000, 100, 0, 0);
    test_random(100);
    set_config(32767, 0, 0, 65535, 65535);
    send_item(ACT_SAMPLE, 5, 1, 0, 0, 0);
    send_item(ACT_SAMPLE, 6, 32767, 0, 0, 0);
    set_config(1200, 1200, 20, 3, 5);
    test_random(50);
    send_idle = 65; recv_idle = 34;
    set_config(1000, 2000, 10, 10, 20);
    test_random(250);
    send_idle = 0; recv_idle = 0;
    set_config(500, 2500, 3, 50, 40);
    test_random(300);
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
